### sv/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and constants of the colour partition distance unit.
// ----------------------------------------------------------------------------
package cpd_pkg;

   localparam int COLOR_W = 4;
   localparam int COUNT_W = 13;
   localparam int CSR_W = 5;
   localparam int MAX_COLORS_DEFAULT = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;
   localparam logic [CSR_W-1:0] CSR_RESET = 5'd16;

   typedef struct packed {
      logic [COLOR_W-1:0] color_a;
      logic [COLOR_W-1:0] color_b;
      logic last;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] proximity;
      logic bad_item;
   } rsp_type;

   typedef struct packed {
      logic restart;
      logic compare;
      logic commit;
   } scan_ctrl_type;

endpackage

### sv/cpd_ram.sv
// ----------------------------------------------------------------------------
// cpd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/cpd_scan_unit.sv
// ----------------------------------------------------------------------------
// cpd_scan_unit
// Shared compare and saturating accumulate unit of the greedy rounds.
// ----------------------------------------------------------------------------
module cpd_scan_unit
   import cpd_pkg::*;
#(
   parameter int IDX_W = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  scan_ctrl_type      ctrl,
   input  logic [COUNT_W-1:0] cmp_data,
   input  logic [IDX_W-1:0]   cmp_row,
   input  logic [IDX_W-1:0]   cmp_col,
   output logic [IDX_W-1:0]   best_row,
   output logic [IDX_W-1:0]   best_col,
   output logic [COUNT_W-1:0] sum
);

   logic               found_ff, found_in;
   logic [COUNT_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]   brow_ff, brow_in;
   logic [IDX_W-1:0]   bcol_ff, bcol_in;
   logic [COUNT_W-1:0] sum_ff, sum_in;
   logic [COUNT_W:0]   sum_wide;

   assign sum_wide = {1'b0, sum_ff} + {1'b0, best_ff};

   always_comb begin
      found_in = found_ff;
      best_in = best_ff;
      brow_in = brow_ff;
      bcol_in = bcol_ff;
      sum_in = sum_ff;
      if (ctrl.restart) begin
         found_in = 1'b0;
         sum_in = '0;
      end else if (ctrl.commit) begin
         found_in = 1'b0;
         sum_in = sum_wide[COUNT_W] ? COUNT_MAX : sum_wide[COUNT_W-1:0];
      end else if (ctrl.compare && (!found_ff || cmp_data > best_ff)) begin
         found_in = 1'b1;
         best_in = cmp_data;
         brow_in = cmp_row;
         bcol_in = cmp_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      brow_ff <= brow_in;
      bcol_ff <= bcol_in;
      sum_ff <= sum_in;
   end

   assign best_row = brow_ff;
   assign best_col = bcol_ff;
   assign sum = sum_ff;

endmodule

### sv/color_partition_distance_unit.sv
// ----------------------------------------------------------------------------
// color_partition_distance_unit
// Greedy proximity of two colourings over a co-occurrence count matrix.
//
// req_* carries one vertex a transfer: its colour in both colourings and a
// last flag. Each item is handled in steps (read, increment, write of one
// count in the matrix RAM); req_stall is high while the block is busy.
// After the last item the sequencer runs n greedy rounds, n being the
// clamped colour count. Each round reads all n*n counts through the single
// RAM read port, one a cycle, and the shared compare unit keeps the largest;
// each round ends with a drain step and a commit step that adds it to the
// saturating sum and retires its row and column.
// The result waits in an output register on rsp_*; a stalled result holds
// and the block keeps taking items meanwhile, but the next result waits
// for it. After each result, and after reset, all MAX_COLORS*MAX_COLORS
// counts are cleared, during which no item is taken. csr_* writes the colour
// count; the user must do so only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module color_partition_distance_unit
   import cpd_pkg::*;
#(
   parameter int MAX_COLORS = MAX_COLORS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data
);

   localparam int DEPTH = MAX_COLORS * MAX_COLORS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W = $clog2(MAX_COLORS);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_INC_RD = 3'd2;
   localparam logic [2:0] S_INC_WR = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_DRAIN  = 3'd5;
   localparam logic [2:0] S_COMMIT = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [CSR_W-1:0]      csr_ff, csr_in;
   req_type               item_ff, item_in;
   logic                  bad_ff, bad_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [IDX_W-1:0]      nm1_ff, nm1_in;
   logic                  bad_seen_ff, bad_seen_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic [IDX_W-1:0]      row_ff, row_in;
   logic [IDX_W-1:0]      col_ff, col_in;
   logic [IDX_W-1:0]      round_ff, round_in;
   logic [MAX_COLORS-1:0] rows_taken_ff, rows_taken_in;
   logic [MAX_COLORS-1:0] cols_taken_ff, cols_taken_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic                  pend_skip_ff, pend_skip_in;
   logic [IDX_W-1:0]      pend_row_ff, pend_row_in;
   logic [IDX_W-1:0]      pend_col_ff, pend_col_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]      nm1_cfg;
   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_wa;
   logic [COUNT_W-1:0]    ram_wd;
   logic [ADDR_W-1:0]     ram_ra;
   logic [COUNT_W-1:0]    ram_rd;
   scan_ctrl_type         ctrl;
   logic [IDX_W-1:0]      best_row;
   logic [IDX_W-1:0]      best_col;
   logic [COUNT_W-1:0]    sum;
   logic [MAX_COLORS-1:0] one_hot;

   assign one_hot = {{(MAX_COLORS-1){1'b0}}, 1'b1};

   always_comb begin
      if (csr_ff == '0) begin
         nm1_cfg = '0;
      end else if (int'(csr_ff) > MAX_COLORS) begin
         nm1_cfg = IDX_W'(MAX_COLORS - 1);
      end else begin
         nm1_cfg = IDX_W'(csr_ff - 5'd1);
      end
   end

   always_comb begin
      state_in = state_ff;
      csr_in = csr_ff;
      item_in = item_ff;
      bad_in = bad_ff;
      addr_in = addr_ff;
      nm1_in = nm1_ff;
      bad_seen_in = bad_seen_ff;
      clr_in = clr_ff;
      row_in = row_ff;
      col_in = col_ff;
      round_in = round_ff;
      rows_taken_in = rows_taken_ff;
      cols_taken_in = cols_taken_ff;
      pend_valid_in = pend_valid_ff;
      pend_skip_in = pend_skip_ff;
      pend_row_in = pend_row_ff;
      pend_col_in = pend_col_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      ram_we = 1'b0;
      ram_wa = clr_ff;
      ram_wd = '0;
      ram_ra = addr_ff;
      ctrl = '0;
      ctrl.compare = pend_valid_ff && !pend_skip_ff;

      if (csr_valid) begin
         csr_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               nm1_in = nm1_cfg;
               bad_in = (int'(req_data.color_a) > int'(nm1_cfg))
                     || (int'(req_data.color_b) > int'(nm1_cfg));
               addr_in = ADDR_W'(int'(req_data.color_a) * MAX_COLORS
                                 + int'(req_data.color_b));
               state_in = S_INC_RD;
            end
         end
         S_INC_RD: begin
            state_in = S_INC_WR;
         end
         S_INC_WR: begin
            if (bad_ff) begin
               bad_seen_in = 1'b1;
            end else begin
               ram_we = 1'b1;
               ram_wa = addr_ff;
               ram_wd = (ram_rd == COUNT_MAX) ? ram_rd : ram_rd + COUNT_W'(1);
            end
            if (item_ff.last) begin
               ctrl.restart = 1'b1;
               rows_taken_in = '0;
               cols_taken_in = '0;
               row_in = '0;
               col_in = '0;
               round_in = '0;
               state_in = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            ram_ra = ADDR_W'(int'(row_ff) * MAX_COLORS + int'(col_ff));
            pend_valid_in = 1'b1;
            pend_skip_in = rows_taken_ff[row_ff] | cols_taken_ff[col_ff];
            pend_row_in = row_ff;
            pend_col_in = col_ff;
            if (col_ff == nm1_ff) begin
               col_in = '0;
               if (row_ff == nm1_ff) begin
                  state_in = S_DRAIN;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            pend_valid_in = 1'b0;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            ctrl.commit = 1'b1;
            rows_taken_in = rows_taken_ff | (one_hot << best_row);
            cols_taken_in = cols_taken_ff | (one_hot << best_col);
            row_in = '0;
            col_in = '0;
            if (round_ff == nm1_ff) begin
               state_in = S_DONE;
            end else begin
               round_in = round_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.proximity = sum;
               rsp_data_in.bad_item = bad_seen_ff;
               bad_seen_in = 1'b0;
               clr_in = '0;
               state_in = S_CLEAR;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         csr_ff <= CSR_RESET;
         bad_seen_ff <= 1'b0;
         clr_ff <= '0;
         rows_taken_ff <= '0;
         cols_taken_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         csr_ff <= csr_in;
         bad_seen_ff <= bad_seen_in;
         clr_ff <= clr_in;
         rows_taken_ff <= rows_taken_in;
         cols_taken_ff <= cols_taken_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      bad_ff <= bad_in;
      addr_ff <= addr_in;
      nm1_ff <= nm1_in;
      row_ff <= row_in;
      col_ff <= col_in;
      round_ff <= round_in;
      pend_skip_ff <= pend_skip_in;
      pend_row_ff <= pend_row_in;
      pend_col_ff <= pend_col_in;
      rsp_data_ff <= rsp_data_in;
   end

   cpd_ram #(
      .WIDTH(COUNT_W),
      .DEPTH(DEPTH)
   ) u_counts (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(ram_ra),
      .rd_data(ram_rd)
   );

   cpd_scan_unit #(
      .IDX_W(IDX_W)
   ) u_scan (
      .clock(clock),
      .reset(reset),
      .ctrl(ctrl),
      .cmp_data(ram_rd),
      .cmp_row(pend_row_ff),
      .cmp_col(pend_col_ff),
      .best_row(best_row),
      .best_col(best_col),
      .sum(sum)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_ram_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || state_ff == S_INC_WR))
      else $error("count RAM written outside clear or increment");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside the done state");

   a_masks_balanced: assert property (@(posedge clock) disable iff (reset)
      $countones(rows_taken_ff) == $countones(cols_taken_ff))
      else $error("retired row and column counts differ");

   a_no_compare_on_commit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COMMIT |-> !pend_valid_ff)
      else $error("pending compare left over at commit");

endmodule

### sim/color_partition_distance_unit_test.sv
// ----------------------------------------------------------------------------
// color_partition_distance_unit_test
// Self-checking bench for the colour partition distance unit. Vertex colour
// pairs are fed in sets closed by the last flag. A tracker holds its own
// copy of the count matrix and the colour count, runs the greedy matching
// when a set closes and queues the proximity it expects. Each result
// transfer is checked against the oldest queued value. The run covers
// directed corner cases and random sets under several colour counts, with
// random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module color_partition_distance_unit_test;
   import cpd_pkg::*;

   localparam int MAX_C = MAX_COLORS_DEFAULT;
   localparam int SETTLE_CYCLES = 300;
   localparam int HOLD_CYCLES = 1500;
   localparam int DRAIN_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 900;
   localparam int PHASES = 11;
   localparam int PAUSE_PHASE = 3;
   localparam int PRINT_LIMIT = 100;

   class proximity_tracker;
      logic [CSR_W-1:0] colors_reg;
      logic [COUNT_W-1:0] pair_counts [MAX_C][MAX_C];
      bit bad_seen;
      rsp_type proximity_due [$];
      int mismatch_count;

      function new();
         colors_reg = CSR_RESET;
         mismatch_count = 0;
         clear_set();
      endfunction

      function void clear_set();
         for (int r = 0; r < MAX_C; r++) begin
            for (int c = 0; c < MAX_C; c++) begin
               pair_counts[r][c] = '0;
            end
         end
         bad_seen = 1'b0;
      endfunction

      function int unsigned colors_in_use();
         if (colors_reg == 0) return 1;
         if (colors_reg > MAX_C) return MAX_C;
         return colors_reg;
      endfunction

      function logic [COUNT_W-1:0] greedy_proximity(int unsigned n);
         bit [MAX_C-1:0] rows_used;
         bit [MAX_C-1:0] cols_used;
         int unsigned total;
         int unsigned best;
         int unsigned best_r;
         int unsigned best_c;
         bit found;
         rows_used = '0;
         cols_used = '0;
         total = 0;
         for (int unsigned round = 0; round < n; round++) begin
            found = 1'b0;
            best = 0;
            best_r = 0;
            best_c = 0;
            for (int unsigned r = 0; r < n; r++) begin
               if (rows_used[r]) continue;
               for (int unsigned c = 0; c < n; c++) begin
                  if (cols_used[c]) continue;
                  if (!found || pair_counts[r][c] > best) begin
                     found = 1'b1;
                     best = pair_counts[r][c];
                     best_r = r;
                     best_c = c;
                  end
               end
            end
            if (!found) break;
            total += best;
            if (total > COUNT_MAX) total = COUNT_MAX;
            rows_used[best_r] = 1'b1;
            cols_used[best_c] = 1'b1;
         end
         return total[COUNT_W-1:0];
      endfunction

      function void take_vertex(req_type item);
         int unsigned n;
         rsp_type outcome;
         n = colors_in_use();
         if (item.color_a >= n || item.color_b >= n) begin
            bad_seen = 1'b1;
         end else if (pair_counts[item.color_a][item.color_b] != COUNT_MAX) begin
            pair_counts[item.color_a][item.color_b]++;
         end
         if (item.last) begin
            outcome.proximity = greedy_proximity(n);
            outcome.bad_item = bad_seen;
            proximity_due.push_back(outcome);
            clear_set();
         end
      endfunction

      task flag_mismatch(input string what);
         mismatch_count++;
         if (mismatch_count <= PRINT_LIMIT) $display("%0t: MISMATCH %s", $time, what);
      endtask

      task compare_proximity(input rsp_type got);
         rsp_type want;
         if (proximity_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result proximity %0d bad_item %0b",
                                    got.proximity, got.bad_item));
         end else begin
            want = proximity_due.pop_front();
            if (got.proximity !== want.proximity) begin
               flag_mismatch($sformatf("proximity %0d, want %0d", got.proximity,
                                       want.proximity));
            end
            if (got.bad_item !== want.bad_item) begin
               flag_mismatch($sformatf("bad_item %0b, want %0b", got.bad_item,
                                       want.bad_item));
            end
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_W-1:0] csr_data = '0;

   bit hold_request = 1'b0;
   int unsigned burst_left = 0;
   proximity_tracker tracker = new();

   color_partition_distance_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.compare_proximity(rsp_data);
   end

   function automatic int unsigned sender_gap();
      int unsigned roll;
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
         burst_left = $urandom_range(30, 150);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic int unsigned set_length();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return $urandom_range(1, 8);
      if (roll < 94) return $urandom_range(9, 40);
      return $urandom_range(41, 120);
   endfunction

   function automatic int unsigned phase_colors(input int p);
      case (p)
         0: return 2;
         1: return 0;
         2: return 1;
         3: return 3;
         4: return 5;
         5: return 8;
         6: return 16;
         7: return 31;
         8: return 4;
         9: return 17;
         default: return 2;
      endcase
   endfunction

   task automatic send_vertex(input int unsigned a, input int unsigned b, input bit last);
      int unsigned gap;
      req_type item;
      gap = sender_gap();
      item.color_a = a[COLOR_W-1:0];
      item.color_b = b[COLOR_W-1:0];
      item.last = last;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      tracker.take_vertex(item);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (tracker.proximity_due.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_colors(input int unsigned value);
      csr_valid <= 1'b1;
      csr_data <= value[CSR_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.colors_reg = value[CSR_W-1:0];
   endtask

   task automatic send_random_set(input int unsigned len, input bit close);
      int unsigned n;
      int unsigned shift;
      int unsigned a;
      int unsigned b;
      n = tracker.colors_in_use();
      shift = $urandom_range(n - 1);
      for (int unsigned i = 0; i < len; i++) begin
         a = $urandom_range(n - 1);
         b = ($urandom_range(99) < 65) ? (a + shift) % n : $urandom_range(n - 1);
         if ($urandom_range(99) < 6) a = $urandom_range(15);
         if ($urandom_range(99) < 6) b = $urandom_range(15);
         send_vertex(a, b, close && i == len - 1);
      end
   endtask

   initial begin : drain_side
      int unsigned roll;
      int unsigned run;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            roll = $urandom_range(99);
            if (roll < 50) begin
               rsp_stall <= 1'b0;
               run = (roll < 5) ? $urandom_range(100, 300) : $urandom_range(1, 30);
            end else begin
               rsp_stall <= 1'b1;
               if (roll < 85) run = $urandom_range(1, 3);
               else if (roll < 97) run = $urandom_range(4, 12);
               else run = $urandom_range(20, 60);
            end
            repeat (run) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int unsigned sent;
      int unsigned len;
      int unsigned phase_end;
      int unsigned waited;
      bit close;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // top colours alone, then ties in row-major order
      send_vertex(15, 15, 1'b1);
      send_vertex(0, 0, 1'b0);
      send_vertex(0, 15, 1'b0);
      send_vertex(15, 0, 1'b0);
      send_vertex(7, 7, 1'b0);
      send_vertex(0, 0, 1'b1);

      // out-of-range colours, one of them on the closing vertex
      settle();
      write_colors(4);
      send_vertex(4, 0, 1'b0);
      send_vertex(0, 15, 1'b1);

      // shrink the colour count mid-set
      send_vertex(3, 3, 1'b0);
      send_vertex(3, 2, 1'b0);
      send_vertex(1, 2, 1'b0);
      settle();
      write_colors(2);
      send_vertex(1, 0, 1'b0);
      send_vertex(1, 0, 1'b1);

      settle();
      write_colors(0);
      send_vertex(0, 0, 1'b0);
      send_vertex(1, 0, 1'b1);

      settle();
      write_colors(31);
      send_vertex(15, 14, 1'b0);
      send_vertex(15, 14, 1'b1);

      sent = 0;
      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_colors(phase_colors(p));
         if (p == 0) hold_request = 1'b1;
         if (p == PAUSE_PHASE) begin
            send_random_set(5, 1'b1);
            sent += 5;
            drain_results();
         end
         phase_end = (p + 1) * RANDOM_ITEMS / PHASES;
         while (sent < phase_end) begin
            len = set_length();
            if (len > phase_end - sent) len = phase_end - sent;
            close = (p == PHASES - 1) || (sent + len < phase_end) || ($urandom_range(99) < 70);
            send_random_set(len, close);
            sent += len;
         end
      end

      req_valid <= 1'b0;
      for (waited = 0; waited < DRAIN_LIMIT && tracker.proximity_due.size() != 0; waited++) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.proximity_due.size() != 0) begin
         tracker.flag_mismatch($sformatf("%0d results never arrived",
                                         tracker.proximity_due.size()));
      end
      if (tracker.mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #100_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
